// File: design/free_list_slot_allocator_unit_assert.svh
// assertion macros used by the checker file of the slot allocator
// needs clk and rst_n in scope where a macro is used
`ifndef FREE_LIST_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FL_ALLOC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// next-cycle implication, checked outside reset
`define FL_ALLOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

// File: design/fl_alloc_pkg.sv
// types and constants of the free list slot allocator
// no dependencies
`default_nettype none

package fl_alloc_pkg;

    localparam int BATCH_MAX = 16;

    typedef enum logic [1:0] {
        OP_ALLOC_ONE   = 2'd0,
        OP_ALLOC_BATCH = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    localparam logic [1:0] TAG_FREE    = 2'd0;
    localparam logic [1:0] TAG_UNTYPED = 2'd1;
    localparam logic [1:0] TAG_SEND    = 2'd2;
    localparam logic [1:0] TAG_RECV    = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic       entry_kind;
        logic [9:0] release_index;
        logic [4:0] batch_count;
    } req_item_t;

    typedef struct packed {
        logic [9:0]  slot_index;
        logic [10:0] request_id;
        logic        granted;
        logic        last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: design/fl_alloc_link_ram.sv
// next-link memory of the free list: one write port, one read port,
// registered read data held until the next read; no dependencies
`default_nettype none

module fl_alloc_link_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/free_list_slot_allocator_unit.sv
// LIFO free list slot allocator: request and response channels with valid/stall
// uses fl_alloc_pkg and fl_alloc_link_ram
//
// usage
//   req carries one transaction per operation: allocate one slot, allocate a
//   batch of up to BATCH_MAX slots, or release a slot. rsp returns one
//   transaction per granted slot (batch: one per slot, last on the final one),
//   one non-granted transaction when nothing is available or a batch of
//   zero is asked, or the released index echoed with last set. opcode 3 is
//   dropped without a response. after reset the link memory is swept once,
//   one entry per cycle, with req stalled until the sweep is done.
//   a release is loaded into the output register from ST_EMIT and a single
//   allocate from ST_POP, and the next request is taken once back in ST_IDLE;
//   a batch of n slots pops one slot per cycle while rsp is not stalled,
//   each pop a read-modify-write of the head through the link memory port.
//   the next request is accepted as soon as the previous one has loaded its
//   last response, even while that response is still waiting in the output
//   register. when rsp is stalled the output register holds and pops wait.
`default_nettype none

module free_list_slot_allocator_unit #(
    parameter int POOL_SLOTS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire fl_alloc_pkg::req_item_t req_item,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output fl_alloc_pkg::rsp_item_t     rsp_item
);

    import fl_alloc_pkg::*;

    localparam int IW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);
    localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_SLOTS - 1);

    state_t          state_reg, state_next;
    logic [LW-1:0]   head_reg, head_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic [4:0]      remain_reg, remain_next;
    logic            batch_reg, batch_next;
    logic            kind_reg, kind_next;
    rsp_item_t       hold_reg, hold_next;
    logic            out_valid_reg, out_valid_next;
    rsp_item_t       out_reg, out_next;

    logic            link_we;
    logic [IW-1:0]   link_waddr;
    logic [LW-1:0]   link_wdata;
    logic            link_re;
    logic [IW-1:0]   link_raddr;
    logic [LW-1:0]   link_rdata;

    logic            tag_we;
    logic [IW-1:0]   tag_addr;
    logic [1:0]      tag_data;
    logic [1:0]      tag_mem [POOL_SLOTS];

    logic            accept;
    logic            out_free;
    logic            load_out;
    rsp_item_t       load_data;
    logic            head_null;
    logic [LW-1:0]   head_norm;
    logic [31:0]     head32;
    logic [31:0]     rel32;
    logic            rel_ok;
    logic [4:0]      cnt_sat;
    logic            pop_last;
    rsp_item_t       no_grant;

    fl_alloc_link_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (LW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (link_re),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    // slot tags, written during the clear sweep and on every pop and release
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_addr] <= tag_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        batch_reg  <= batch_next;
        kind_reg   <= kind_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        head32    = 32'(head_reg);
        rel32     = 32'(req_item.release_index);
        head_null = (head_reg >= NULL_LINK);
        head_norm = head_null ? NULL_LINK : head_reg;
        rel_ok    = (rel32 < 32'(POOL_SLOTS));
        cnt_sat   = (32'(req_item.batch_count) > 32'(BATCH_MAX)) ?
                    5'(BATCH_MAX) : req_item.batch_count;
        pop_last  = !batch_reg || (remain_reg == 5'd1) || (link_rdata >= NULL_LINK);
        no_grant  = '{slot_index: '0, request_id: '0, granted: 1'b0, last: 1'b1};
        out_free  = !out_valid_reg || !rsp_stall;
        req_stall = (state_reg != ST_IDLE);
        accept    = req_valid && !req_stall;

        state_next  = state_reg;
        head_next   = head_reg;
        clr_next    = clr_reg;
        remain_next = remain_reg;
        batch_next  = batch_reg;
        kind_next   = kind_reg;
        hold_next   = hold_reg;

        link_we    = 1'b0;
        link_waddr = clr_reg;
        link_wdata = LW'(clr_reg) + LW'(1);
        link_re    = 1'b0;
        link_raddr = head_reg[IW-1:0];
        tag_we     = 1'b0;
        tag_addr   = clr_reg;
        tag_data   = TAG_FREE;
        load_out   = 1'b0;
        load_data  = hold_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                link_we = 1'b1;
                tag_we  = 1'b1;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_item.opcode)
                        OP_ALLOC_ONE:
                        begin
                            if (head_null)
                            begin
                                hold_next  = no_grant;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                link_re     = 1'b1;
                                batch_next  = 1'b0;
                                kind_next   = req_item.entry_kind;
                                remain_next = 5'd1;
                                state_next  = ST_POP;
                            end
                        end
                        OP_ALLOC_BATCH:
                        begin
                            if (head_null || (cnt_sat == 5'd0))
                            begin
                                hold_next  = no_grant;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                link_re     = 1'b1;
                                batch_next  = 1'b1;
                                remain_next = cnt_sat;
                                state_next  = ST_POP;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (rel_ok)
                            begin
                                link_we    = 1'b1;
                                link_waddr = rel32[IW-1:0];
                                link_wdata = head_norm;
                                tag_we     = 1'b1;
                                tag_addr   = rel32[IW-1:0];
                                tag_data   = TAG_FREE;
                                head_next  = LW'(rel32);
                            end
                            hold_next = '{slot_index: req_item.release_index,
                                          request_id: '0, granted: 1'b0, last: 1'b1};
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // link_rdata holds the link of the current head
                if (out_free)
                begin
                    load_out  = 1'b1;
                    load_data = '{slot_index: head32[9:0],
                                  request_id: head32[10:0] + 11'd1,
                                  granted: 1'b1, last: pop_last};
                    tag_we    = 1'b1;
                    tag_addr  = head_reg[IW-1:0];
                    tag_data  = batch_reg ? TAG_UNTYPED : (kind_reg ? TAG_RECV : TAG_SEND);
                    head_next = link_rdata;
                    if (pop_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 5'd1;
                        link_re     = 1'b1;
                        link_raddr  = link_rdata[IW-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_data  = hold_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        out_next = out_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = load_data;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

`default_nettype wire

// File: design/fl_alloc_checker.sv
// port-level checks of the slot allocator and their bind to the top level
// uses fl_alloc_pkg and free_list_slot_allocator_unit_assert.svh
`default_nettype none
`include "free_list_slot_allocator_unit_assert.svh"

module fl_alloc_checker (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    input  wire logic                    req_stall,
    input  wire fl_alloc_pkg::req_item_t req_item,
    input  wire logic                    rsp_valid,
    input  wire logic                    rsp_stall,
    input  wire fl_alloc_pkg::rsp_item_t rsp_item
);

    import fl_alloc_pkg::*;

    logic req_seen;

    assign req_seen = req_valid && !req_stall && (req_item.opcode != OP_NONE);

    // a stalled response transaction holds
    `FL_ALLOC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
    // an accepted operation keeps req busy for at least the next cycle
    `FL_ALLOC_ASSERT_NEXT(a_busy_after_req, req_seen, req_stall)
    // a grant carries its own slot plus one as request id
    `FL_ALLOC_ASSERT_IMPL(a_grant_id, rsp_valid && rsp_item.granted,
        rsp_item.request_id == {1'b0, rsp_item.slot_index} + 11'd1)
    // no grant means no request id and the end of the transaction's responses
    `FL_ALLOC_ASSERT_IMPL(a_nogrant_id, rsp_valid && !rsp_item.granted,
        rsp_item.request_id == 11'd0)
    `FL_ALLOC_ASSERT_IMPL(a_nogrant_last, rsp_valid && !rsp_item.granted, rsp_item.last)

endmodule

bind free_list_slot_allocator_unit fl_alloc_checker u_fl_alloc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench of free_list_slot_allocator_unit: queue-fed driver, posedge monitor
// keeps its own copy of the free list to predict every response transaction
// depends on fl_alloc_pkg and the allocator rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fl_alloc_pkg::*;

    localparam int POOL = 1024;
    localparam int REQ_BITS = $bits(req_item_t);
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    // free list copy used for prediction
    logic [10:0] head_ptr;
    logic [10:0] link_mem [POOL];
    logic [1:0]  tag_mem [POOL];
    bit          release_queued [POOL];

    req_item_t   pending [$];
    rsp_item_t   awaited_rsp [$];
    bit          req_took = 1'b0;
    bit          idle_on = 1'b1;
    int unsigned req_gap = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int          fail_count = 0;

    free_list_slot_allocator_unit #(
        .POOL_SLOTS(POOL)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_item (req_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item (rsp_item)
    );

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (!idle_on || roll < 55)
            pick_gap = 0;
        else if (roll < 90)
            pick_gap = $urandom_range(3, 1);
        else
            pick_gap = $urandom_range(40, 8);
    endfunction

    function automatic void expect_rsp(logic [9:0] idx, logic [10:0] id, logic g, logic l);
        rsp_item_t e;
        e.slot_index = idx;
        e.request_id = id;
        e.granted = g;
        e.last = l;
        awaited_rsp.push_back(e);
    endfunction

    function automatic void predict_grants(req_item_t r);
        logic [9:0]  popped [BATCH_MAX];
        int unsigned want;
        int unsigned got;
        logic [10:0] s;
        case (r.opcode)
            OP_ALLOC_ONE:
            begin
                if (head_ptr >= POOL)
                    expect_rsp('0, '0, 1'b0, 1'b1);
                else
                begin
                    s = head_ptr;
                    head_ptr = link_mem[s];
                    tag_mem[s] = r.entry_kind ? TAG_RECV : TAG_SEND;
                    expect_rsp(s[9:0], s + 11'd1, 1'b1, 1'b1);
                end
            end
            OP_ALLOC_BATCH:
            begin
                want = (r.batch_count > BATCH_MAX) ? BATCH_MAX : r.batch_count;
                got = 0;
                while (got < want && head_ptr < POOL)
                begin
                    popped[got] = head_ptr[9:0];
                    tag_mem[head_ptr] = TAG_UNTYPED;
                    head_ptr = link_mem[head_ptr];
                    got++;
                end
                if (got == 0)
                    expect_rsp('0, '0, 1'b0, 1'b1);
                else
                    for (int k = 0; k < got; k++)
                        expect_rsp(popped[k], {1'b0, popped[k]} + 11'd1, 1'b1, k == got - 1);
            end
            OP_RELEASE:
            begin
                tag_mem[r.release_index] = TAG_FREE;
                link_mem[r.release_index] = (head_ptr < POOL) ? head_ptr : 11'(POOL);
                head_ptr = {1'b0, r.release_index};
                release_queued[r.release_index] = 1'b0;
                expect_rsp(r.release_index, '0, 1'b0, 1'b1);
            end
            default:
            begin
                // dropped without a response
            end
        endcase
    endfunction

    task automatic check_rsp(rsp_item_t actual);
        rsp_item_t want;
        if (awaited_rsp.size() == 0)
        begin
            $error("response with none pending: slot_index %0d request_id %0d granted %0d last %0d",
                   actual.slot_index, actual.request_id, actual.granted, actual.last);
            fail_count++;
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (actual.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, actual %0d", want.slot_index, actual.slot_index);
                fail_count++;
            end
            if (actual.request_id !== want.request_id)
            begin
                $error("request_id: expected %0d, actual %0d", want.request_id, actual.request_id);
                fail_count++;
            end
            if (actual.granted !== want.granted)
            begin
                $error("granted: expected %0d, actual %0d", want.granted, actual.granted);
                fail_count++;
            end
            if (actual.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, actual.last);
                fail_count++;
            end
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_took))
        begin
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending.size() > 0)
            begin
                req_item <= pending.pop_front();
                req_valid <= 1'b1;
                req_gap <= pick_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        req_took <= rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                predict_grants(req_item);
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp_item);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_req(opcode_t op, logic kind, logic [9:0] idx, logic [4:0] cnt);
        req_item_t r;
        r.opcode = op;
        r.entry_kind = kind;
        r.release_index = idx;
        r.batch_count = cnt;
        pending.push_back(r);
    endtask

    // a held slot that has no release queued yet; such a slot stays held until
    // its release is accepted, so the lagging model state is safe to use here
    function automatic bit pick_held(output logic [9:0] slot);
        int unsigned start;
        int unsigned j;
        start = $urandom_range(POOL - 1);
        slot = '0;
        pick_held = 1'b0;
        for (int k = 0; k < POOL; k++)
        begin
            j = (start + k) % POOL;
            if (!pick_held && tag_mem[j] != TAG_FREE && !release_queued[j])
            begin
                slot = j[9:0];
                pick_held = 1'b1;
            end
        end
    endfunction

    function automatic logic [4:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            pick_count = 5'($urandom_range(4));
        else if (roll < 90)
            pick_count = 5'($urandom_range(16, 5));
        else
            pick_count = 5'($urandom_range(31, 17));
    endfunction

    task automatic queue_mixed_item();
        req_item_t   r;
        logic [9:0]  s;
        int unsigned roll;
        r = req_item_t'(REQ_BITS'($urandom));
        r.opcode = OP_ALLOC_ONE;
        roll = $urandom_range(99);
        if (roll < 30)
            r.opcode = OP_ALLOC_ONE;
        else if (roll < 60)
        begin
            r.opcode = OP_ALLOC_BATCH;
            r.batch_count = pick_count();
        end
        else if (roll < 95)
        begin
            if (pick_held(s))
            begin
                r.opcode = OP_RELEASE;
                r.release_index = s;
                release_queued[s] = 1'b1;
            end
        end
        else
            r.opcode = OP_NONE;
        pending.push_back(r);
    endtask

    // holds the sender until every queued transaction has been answered
    task automatic wait_quiet();
        do @(posedge clk); while (pending.size() != 0 || req_valid);
        do @(negedge clk); while (awaited_rsp.size() != 0);
    endtask

    initial
    begin
        req_item_t   r;
        int unsigned slots_left;
        int unsigned take;

        for (int k = 0; k < POOL; k++)
        begin
            link_mem[k] = 11'(k + 1);
            tag_mem[k] = TAG_FREE;
            release_queued[k] = 1'b0;
        end
        head_ptr = '0;

        // directed: field extremes, saturation, lifo reuse, dropped opcode
        queue_req(OP_ALLOC_ONE, 1'b0, 10'd0, 5'd0);
        queue_req(OP_ALLOC_ONE, 1'b1, 10'd1023, 5'd31);
        queue_req(OP_ALLOC_BATCH, 1'b1, 10'd1023, 5'd0);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd1);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd16);
        queue_req(OP_ALLOC_BATCH, 1'b1, 10'd512, 5'd17);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd31);
        queue_req(OP_NONE, 1'b1, 10'd1023, 5'd31);
        queue_req(OP_RELEASE, 1'b0, 10'd0, 5'd0);
        queue_req(OP_ALLOC_ONE, 1'b1, 10'd0, 5'd0);
        queue_req(OP_RELEASE, 1'b1, 10'd1, 5'd16);
        queue_req(OP_RELEASE, 1'b0, 10'd2, 5'd0);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd3);
        queue_req(OP_RELEASE, 1'b0, 10'd18, 5'd0);
        queue_req(OP_RELEASE, 1'b0, 10'd50, 5'd0);
        queue_req(OP_NONE, 1'b0, 10'd0, 5'd0);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd2);
        queue_req(OP_ALLOC_ONE, 1'b0, 10'd0, 5'd0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_quiet();

        // well-formed mix: releases only of held slots
        for (int n = 0; n < 35; n++)
        begin
            while (pending.size() > 3) @(negedge clk);
            queue_mixed_item();
        end

        // empty the pool back to back, then hit it while empty
        wait_quiet();
        idle_on = 1'b0;
        slots_left = 0;
        for (int k = 0; k < POOL; k++)
            if (tag_mem[k] == TAG_FREE)
                slots_left++;
        while (slots_left > 0)
        begin
            r = req_item_t'(REQ_BITS'($urandom));
            r.opcode = OP_ALLOC_BATCH;
            r.batch_count = 5'($urandom_range(31, 8));
            pending.push_back(r);
            take = (r.batch_count > BATCH_MAX) ? BATCH_MAX : r.batch_count;
            slots_left = (take >= slots_left) ? 0 : slots_left - take;
        end
        queue_req(OP_ALLOC_ONE, 1'b0, 10'd0, 5'd0);
        queue_req(OP_ALLOC_ONE, 1'b1, 10'd0, 5'd0);
        queue_req(OP_ALLOC_BATCH, 1'b0, 10'd0, 5'd16);
        wait_quiet();
        idle_on = 1'b1;

        release_queued[1023] = 1'b1;
        queue_req(OP_RELEASE, 1'b1, 10'd1023, 5'd31);
        for (int n = 0; n < 35; n++)
        begin
            while (pending.size() > 3) @(negedge clk);
            queue_mixed_item();
        end

        // noise last: any field values, double releases included
        for (int n = 0; n < 25; n++)
        begin
            while (pending.size() > 3) @(negedge clk);
            r = req_item_t'(REQ_BITS'($urandom));
            pending.push_back(r);
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
